>>> design/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg: shared types and helpers for the CAN signal pack/unpack block
// Item and result beats, action and status codes, datapath command set.
// ----------------------------------------------------------------------------
package csp_pkg;

	localparam int unsigned FrameBytesDef = 8;

	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_CLEAR   = 2'd1;
	localparam logic [1:0] ACT_INSERT  = 2'd2;
	localparam logic [1:0] ACT_EXTRACT = 2'd3;

	localparam logic [1:0] ORDER_INTEL    = 2'd0;
	localparam logic [1:0] ORDER_MOTOROLA = 2'd1;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_RANGE       = 2'd1;
	localparam logic [1:0] ST_ZERO_FACTOR = 2'd2;
	localparam logic [1:0] ST_BAD_ORDER   = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic [63:0]        payload_in;
		logic [5:0]         anchor_bit;
		logic [6:0]         bit_length;
		logic [1:0]         endian_sel;
		logic               raw_is_signed;
		logic signed [31:0] scale_factor;
		logic signed [63:0] scale_offset;
		logic signed [63:0] min_limit;
		logic signed [63:0] max_limit;
		logic signed [63:0] phys_in;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [63:0] phys_out;
		logic [63:0]        raw_out;
		logic [63:0]        frame_out;
	} out_item_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_CAPTURE, CMD_CLAMP, CMD_DIFF, CMD_DIV,
		CMD_GATHER, CMD_MUL_LO, CMD_MUL_HI, CMD_SUM, CMD_ACC, CMD_FINISH
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       err;
	} dp_stat_t;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		mag64 = v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] bswap64(input logic [63:0] v);
		logic [63:0] r;
		r = '0;
		for (int k = 0; k < 8; k++) begin
			r[8*k +: 8] = v[8*(7-k) +: 8];
		end
		bswap64 = r;
	endfunction

endpackage

>>> design/csp_ctrl.sv
// ----------------------------------------------------------------------------
// csp_ctrl: sequencer for the CAN signal pack/unpack block
// Steps the datapath through decode, divide or multiply, and result.
// ----------------------------------------------------------------------------
module csp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output csp_pkg::dp_cmd_t   cmd,
	input  csp_pkg::dp_stat_t  stat
);
	import csp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_CLAMP, S_DIFF, S_DIV,
		S_GATHER, S_MUL_LO, S_MUL_HI, S_SUM, S_ACC, S_FINISH
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic       done_q;
	logic       accept;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign accept = start && !busy;

	always_comb begin
		unique case (state_q)
			S_IDLE:   cmd.op = accept ? CMD_CAPTURE : CMD_NONE;
			S_DECODE: cmd.op = CMD_NONE;
			S_CLAMP:  cmd.op = CMD_CLAMP;
			S_DIFF:   cmd.op = CMD_DIFF;
			S_DIV:    cmd.op = CMD_DIV;
			S_GATHER: cmd.op = CMD_GATHER;
			S_MUL_LO: cmd.op = CMD_MUL_LO;
			S_MUL_HI: cmd.op = CMD_MUL_HI;
			S_SUM:    cmd.op = CMD_SUM;
			S_ACC:    cmd.op = CMD_ACC;
			S_FINISH: cmd.op = CMD_FINISH;
			default:  cmd.op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_FINISH);
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (stat.err || stat.action == ACT_LOAD || stat.action == ACT_CLEAR)
						state_q <= S_FINISH;
					else if (stat.action == ACT_INSERT)
						state_q <= S_CLAMP;
					else
						state_q <= S_GATHER;
				end
				S_CLAMP: state_q <= S_DIFF;
				S_DIFF: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= S_FINISH;
				end
				S_GATHER: state_q <= S_MUL_LO;
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_SUM;
				S_SUM:    state_q <= S_ACC;
				S_ACC:    state_q <= S_FINISH;
				S_FINISH: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("accepted beat did not raise busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(state_q == S_FINISH))
		else $error("result strobe outside finish");

endmodule

>>> design/csp_datapath.sv
// ----------------------------------------------------------------------------
// csp_datapath: frame register, field mapper, divider and multiplier
// Executes one command per cycle from the sequencer.
// ----------------------------------------------------------------------------
module csp_datapath #(
	parameter int unsigned FRAME_BYTES = csp_pkg::FrameBytesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  csp_pkg::in_item_t   item,
	input  csp_pkg::dp_cmd_t    cmd,
	output csp_pkg::dp_stat_t   stat,
	output csp_pkg::out_item_t  result
);
	import csp_pkg::*;

	localparam logic [7:0]  FrameBits = 8'(8 * FRAME_BYTES);
	localparam logic [63:0] FrameMask = {64{1'b1}} >> (64 - 8 * FRAME_BYTES);

	in_item_t    in_q;
	logic [63:0] frame_q;
	logic [63:0] v_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic        qneg_q;
	logic [63:0] raw_q;
	logic        rneg_q;
	logic [63:0] rmag_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	logic [63:0] prod_q;
	logic        over_q;
	logic        pneg_q;
	logic [63:0] phys_q;
	out_item_t   res_q;

	// descriptor decode
	logic        fneg;
	logic [31:0] fmag;
	logic        len_bad, span_ok, order_bad;
	logic [6:0]  first, lsb7;
	logic [5:0]  lsb;
	logic [63:0] lmask, fmask, view;
	logic [1:0]  err_code;

	assign fneg      = in_q.scale_factor[31];
	assign fmag      = fneg ? (32'd0 - in_q.scale_factor) : in_q.scale_factor;
	assign len_bad   = (in_q.bit_length == 7'd0) || (in_q.bit_length > 7'd64);
	assign order_bad = in_q.endian_sel[1];
	assign first     = (in_q.endian_sel == ORDER_INTEL) ? {1'b0, in_q.anchor_bit}
		: {1'b0, in_q.anchor_bit[5:3], ~in_q.anchor_bit[2:0]};
	assign span_ok   = ({1'b0, first} + {1'b0, in_q.bit_length}) <= FrameBits;
	// Motorola fields become Intel fields in the byte-swapped frame
	assign lsb7      = (in_q.endian_sel == ORDER_INTEL) ? first
		: (7'd64 - first - in_q.bit_length);
	assign lsb       = lsb7[5:0];
	assign lmask     = ~({64{1'b1}} << in_q.bit_length);
	assign fmask     = lmask << lsb;
	assign view      = (in_q.endian_sel == ORDER_INTEL) ? frame_q : bswap64(frame_q);

	always_comb begin
		err_code = ST_OK;
		if (in_q.action == ACT_INSERT) begin
			if (len_bad)            err_code = ST_RANGE;
			else if (fmag == '0)    err_code = ST_ZERO_FACTOR;
			else if (order_bad)     err_code = ST_BAD_ORDER;
			else if (!span_ok)      err_code = ST_RANGE;
		end else if (in_q.action == ACT_EXTRACT) begin
			if (order_bad)          err_code = ST_BAD_ORDER;
			else if (len_bad)       err_code = ST_RANGE;
			else if (!span_ok)      err_code = ST_RANGE;
		end
	end

	assign stat.action = in_q.action;
	assign stat.err    = (err_code != ST_OK);
	assign result      = res_q;

	// clamp, max first then min
	logic [63:0] v_hi, v_cl;
	always_comb begin
		v_hi = ($signed(in_q.max_limit) < $signed(in_q.phys_in)) ? in_q.max_limit : in_q.phys_in;
		v_cl = ($signed(v_hi) < $signed(in_q.min_limit)) ? in_q.min_limit : v_hi;
	end

	// difference v - offset, sign and magnitude
	logic [63:0] vmag, omag, dmag;
	logic        dneg;
	always_comb begin
		vmag = mag64(v_q);
		omag = mag64(in_q.scale_offset);
		if (v_q[63] == !in_q.scale_offset[63]) begin
			dmag = vmag + omag;
			dneg = v_q[63];
		end else if (vmag >= omag) begin
			dmag = vmag - omag;
			dneg = v_q[63];
		end else begin
			dmag = omag - vmag;
			dneg = !in_q.scale_offset[63];
		end
	end

	// restoring divide step
	logic [32:0] trial;
	logic        ge;
	assign trial = {rem_q, quo_q[63]};
	assign ge    = trial >= {1'b0, fmag};

	// field gather
	logic [63:0] gath, gext;
	logic        gsign;
	always_comb begin
		gath  = (view >> lsb) & lmask;
		gsign = in_q.raw_is_signed && gath[6'(in_q.bit_length - 7'd1)];
		gext  = gath | ~lmask;
	end

	// product plus offset, saturated
	logic [95:0] sum96;
	logic [64:0] acc65;
	logic [63:0] amag, phys_n;
	logic        aneg, aover;
	assign sum96 = {32'd0, lo_q} + {hi_q, 32'd0};
	always_comb begin
		aover = 1'b0;
		acc65 = '0;
		if (pneg_q == in_q.scale_offset[63]) begin
			acc65 = {1'b0, prod_q} + {1'b0, omag};
			amag  = acc65[63:0];
			aneg  = pneg_q;
			aover = acc65[64];
		end else if (prod_q >= omag) begin
			amag = prod_q - omag;
			aneg = pneg_q;
		end else begin
			amag = omag - prod_q;
			aneg = in_q.scale_offset[63];
		end
		if (over_q)
			phys_n = pneg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		else if (aneg)
			phys_n = (aover || amag > 64'h8000_0000_0000_0000)
				? 64'h8000_0000_0000_0000 : (64'd0 - amag);
		else
			phys_n = (aover || amag[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : amag;
	end

	// insert write-back
	logic [63:0] ins_raw, ins_view, ins_frame;
	always_comb begin
		ins_raw   = (qneg_q ? (64'd0 - quo_q) : quo_q) & lmask;
		ins_view  = (view & ~fmask) | (ins_raw << lsb);
		ins_frame = (in_q.endian_sel == ORDER_INTEL) ? ins_view : bswap64(ins_view);
	end

	// result beat; errors report the old frame and zero values
	out_item_t res_n;
	always_comb begin
		res_n.status    = err_code;
		res_n.phys_out  = '0;
		res_n.raw_out   = '0;
		res_n.frame_out = frame_q;
		if (err_code == ST_OK) begin
			case (in_q.action)
				ACT_LOAD:   res_n.frame_out = in_q.payload_in & FrameMask;
				ACT_CLEAR:  res_n.frame_out = '0;
				ACT_INSERT: begin
					res_n.raw_out   = ins_raw;
					res_n.frame_out = ins_frame;
				end
				default: begin
					res_n.raw_out  = raw_q;
					res_n.phys_out = phys_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (cmd.op == CMD_FINISH && err_code == ST_OK) begin
			case (in_q.action)
				ACT_LOAD:   frame_q <= in_q.payload_in & FrameMask;
				ACT_CLEAR:  frame_q <= '0;
				ACT_INSERT: frame_q <= ins_frame;
				default:    frame_q <= frame_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_CAPTURE: in_q <= item;
			CMD_CLAMP:   v_q <= v_cl;
			CMD_DIFF: begin
				rem_q  <= '0;
				quo_q  <= dmag;
				qneg_q <= dneg != fneg;
			end
			CMD_DIV: begin
				rem_q <= ge ? 32'(trial - {1'b0, fmag}) : trial[31:0];
				quo_q <= {quo_q[62:0], ge};
			end
			CMD_GATHER: begin
				raw_q  <= gath;
				rneg_q <= gsign;
				rmag_q <= gsign ? (64'd0 - gext) : gath;
			end
			CMD_MUL_LO: lo_q <= rmag_q[31:0] * fmag;
			CMD_MUL_HI: hi_q <= rmag_q[63:32] * fmag;
			CMD_SUM: begin
				prod_q <= sum96[63:0];
				over_q <= |sum96[95:64];
				pneg_q <= rneg_q != fneg;
			end
			CMD_ACC:    phys_q <= phys_n;
			CMD_FINISH: res_q <= res_n;
			default: ;
		endcase
	end

	a_frame_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != CMD_FINISH) |=> $stable(frame_q))
		else $error("frame changed outside finish");
	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CMD_FINISH && err_code != ST_OK) |=> $stable(frame_q))
		else $error("frame changed on error");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CMD_DIV) |-> (rem_q < fmag))
		else $error("divider remainder out of range");

endmodule

>>> design/can_signal_pack_unpack.sv
// ----------------------------------------------------------------------------
// can_signal_pack_unpack: CAN payload register with DBC signal insert/extract
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// One beat at a time: a beat is taken when start is high and busy is low,
// and its result appears for exactly one cycle with done high. The receiver
// cannot stall, so capture result on done. Load and clear, and any beat that
// fails its descriptor checks, go from decode straight to the result. Extract
// runs field gather, two 32x32 partial products, product sum and offset add
// with saturation. Insert runs the clamp, the difference and then the
// bit-serial 64-by-32 restoring divider that turns (value - offset) into the
// raw count one quotient bit per cycle. busy drops in the cycle done is
// shown, so the next beat may start then. Errors leave the payload untouched
// and report zero raw and physical values.
module can_signal_pack_unpack #(
	parameter int unsigned FRAME_BYTES = csp_pkg::FrameBytesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  csp_pkg::in_item_t   item,
	output logic                done,
	output csp_pkg::out_item_t  result
);
	import csp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequence the beat
	csp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// hold the frame and do the arithmetic
	csp_datapath #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

>>> test/can_signal_pack_unpack_test.sv
// ----------------------------------------------------------------------------
// can_signal_pack_unpack_test: self-checking bench for the CAN signal engine
// Drives load, clear, insert and extract beats through the start/busy
// handshake, predicts every result from a behavioral frame model and checks
// each done beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module can_signal_pack_unpack_test;
	timeunit 1ns;
	timeprecision 1ps;
	import csp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BEATS   = 1050;

	// Scoreboard: owns the payload model and the queue of predicted results.
	class frame_scoreboard;
		logic [63:0] payload;
		out_item_t   pending[$];
		int          mismatches;
		int          checked;
		int          hits[4];

		function new();
			payload    = '0;
			mismatches = 0;
			checked    = 0;
		endfunction

		// Map step j of the bit walk onto a frame bit position.
		function automatic int bit_pos(int first, logic [1:0] order, int j);
			int k;
			if (order == ORDER_INTEL) begin
				return (first + j) & 63;
			end
			k = (first + j) & 63;
			return (k / 8) * 8 + (7 - (k % 8));
		endfunction

		// Work out the result of one accepted beat and advance the payload.
		function void note_beat(in_item_t b);
			out_item_t   r;
			logic [63:0] fmag, dmag, quo, rmag, frame;
			logic [127:0] prod;
			logic signed [65:0] vval, offv, sum;
			logic signed [129:0] pval;
			logic        fneg, dneg, rneg;
			int          first, len, rb;
			r     = '0;
			len   = int'(b.bit_length);
			fneg  = b.scale_factor[31];
			fmag  = fneg ? 64'(-$signed({32'hffffffff, b.scale_factor})) :
				{32'd0, b.scale_factor};
			first = (b.endian_sel == ORDER_INTEL) ? int'(b.anchor_bit) :
				(b.anchor_bit / 8) * 8 + (7 - (b.anchor_bit % 8));
			case (b.action)
				ACT_LOAD: begin
					payload = b.payload_in;
				end
				ACT_CLEAR: begin
					payload = '0;
				end
				ACT_INSERT: begin
					if (len == 0 || len > 64) r.status = ST_RANGE;
					else if (fmag == 0) r.status = ST_ZERO_FACTOR;
					else if (b.endian_sel > ORDER_MOTOROLA) r.status = ST_BAD_ORDER;
					else if (first + len > 64) r.status = ST_RANGE;
					else begin
						vval = b.phys_in;
						if (b.max_limit < vval) vval = b.max_limit;
						if (vval < b.min_limit) vval = b.min_limit;
						offv = b.scale_offset;
						sum  = vval - offv;
						dneg = sum[65];
						dmag = 64'(dneg ? -sum : sum);
						quo  = dmag / fmag;
						r.raw_out = (dneg != fneg) ? -quo : quo;
						if (len < 64) r.raw_out &= (64'd1 << len) - 1;
						frame = payload;
						for (int j = 0; j < len; j++) begin
							rb = (b.endian_sel == ORDER_INTEL) ? j : len - 1 - j;
							frame[bit_pos(first, b.endian_sel, j)] = r.raw_out[rb];
						end
						payload = frame;
					end
				end
				default: begin
					if (b.endian_sel > ORDER_MOTOROLA) r.status = ST_BAD_ORDER;
					else if (len == 0 || len > 64) r.status = ST_RANGE;
					else if (first + len > 64) r.status = ST_RANGE;
					else begin
						for (int j = 0; j < len; j++) begin
							rb = (b.endian_sel == ORDER_INTEL) ? j : len - 1 - j;
							r.raw_out[rb] = payload[bit_pos(first, b.endian_sel, j)];
						end
						rneg = b.raw_is_signed && r.raw_out[len-1];
						rmag = r.raw_out;
						if (rneg) begin
							if (len < 64) rmag |= ~64'd0 << len;
							rmag = -rmag;
						end
						prod = {64'd0, rmag} * {64'd0, fmag};
						pval = (rneg != fneg) ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
						pval = pval + b.scale_offset;
						if (pval > 130'sh7fffffffffffffff) r.phys_out = 64'h7fffffffffffffff;
						else if (pval < -130'sh8000000000000000)
							r.phys_out = 64'h8000000000000000;
						else r.phys_out = pval[63:0];
					end
				end
			endcase
			r.frame_out = payload;
			hits[b.action]++;
			pending.push_back(r);
		endfunction

		// Compare one done beat with the oldest prediction.
		function void check_result(out_item_t got);
			out_item_t want;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result with nothing pending: %p", got);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status || got.phys_out !== want.phys_out ||
			    got.raw_out !== want.raw_out || got.frame_out !== want.frame_out) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch st %0d/%0d phys %h/%h raw %h/%h frame %h/%h",
						want.status, got.status, want.phys_out, got.phys_out,
						want.raw_out, got.raw_out, want.frame_out, got.frame_out);
				end
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	logic      done;
	out_item_t result;

	frame_scoreboard board;
	int  quiet_cycles;
	bit  idle_gaps;

	can_signal_pack_unpack DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.done  (done),
		.result(result)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every done beat; note every accepted command; feed the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) board.check_result(result);
			if (start && !busy) board.note_beat(item);
			if (done || (start && !busy)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", board.pending.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Idle for a few random cycles if gaps are on, then present one beat and
	// hold it until accepted. start stays high so a follow-on beat can go
	// straight out; callers that pause drop it themselves.
	task automatic send_beat(in_item_t b);
		if (idle_gaps) begin
			while ($urandom_range(99) < 33) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		item  <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Random descriptor; lengths lean toward fields that fit in the frame.
	function automatic in_item_t random_beat();
		in_item_t b;
		b.action     = 2'($urandom_range(3));
		b.payload_in = rand64();
		b.anchor_bit = 6'($urandom_range(63));
		b.bit_length = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
			: 7'($urandom_range(64, 1));
		b.endian_sel = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2))
			: 2'($urandom_range(1));
		if ($urandom_range(3) == 0 && b.bit_length <= 64 && b.bit_length > 0) begin
			// For Intel order, pull the start back so the field lands inside the frame.
			if (b.endian_sel == ORDER_INTEL)
				b.anchor_bit = 6'($urandom_range(64 - b.bit_length));
		end
		b.raw_is_signed = 1'($urandom_range(1));
		case ($urandom_range(3))
			0: b.scale_factor = 32'sh10000;
			1: b.scale_factor = $signed(32'($urandom_range(32'h3ffff)) - 32'sh20000);
			2: b.scale_factor = (($urandom_range(15) == 0) ? 32'sd0 : $urandom);
			default: b.scale_factor = $urandom;
		endcase
		b.scale_offset = ($urandom_range(1)) ? 64'($signed(32'($urandom))) : rand64();
		b.min_limit    = ($urandom_range(1)) ? 64'h8000000000000000 : rand64();
		b.max_limit    = ($urandom_range(1)) ? 64'h7fffffffffffffff : rand64();
		b.phys_in      = ($urandom_range(1)) ? 64'($signed(40'({$urandom, 8'($urandom)})))
			: rand64();
		return b;
	endfunction

	// Drop start and hold off until every outstanding result has come back.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		in_item_t b;
		board     = new();
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		idle_gaps = 1'b0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: load extremes, clear, both orders at the frame edges,
		// each error code and its priority, saturation on extract.
		b = '0;
		b.scale_factor = 32'sh10000;
		b.max_limit = 64'h7fffffffffffffff;
		b.min_limit = 64'h8000000000000000;
		b.action = ACT_LOAD; b.payload_in = '1; send_beat(b);
		b.action = ACT_EXTRACT; b.bit_length = 7'd64; b.raw_is_signed = 1'b1; send_beat(b);
		b.raw_is_signed = 1'b0; b.scale_factor = 32'sh7fffffff; send_beat(b);
		b.scale_factor = 32'sh80000000; send_beat(b);
		b.action = ACT_CLEAR; send_beat(b);
		b.action = ACT_LOAD; b.payload_in = 64'h0123456789abcdef; send_beat(b);
		b.action = ACT_EXTRACT; b.endian_sel = ORDER_MOTOROLA; b.anchor_bit = 6'd7;
		b.bit_length = 7'd64; b.scale_factor = 32'sh10000; send_beat(b);
		b.anchor_bit = 6'd0; b.bit_length = 7'd2; send_beat(b);
		b.endian_sel = 2'd3; send_beat(b);
		b.endian_sel = ORDER_INTEL; b.bit_length = 7'd0; send_beat(b);
		b.bit_length = 7'd65; send_beat(b);
		b.anchor_bit = 6'd63; b.bit_length = 7'd2; send_beat(b);
		b.action = ACT_INSERT; b.scale_factor = 32'sd0; b.bit_length = 7'd0; send_beat(b);
		b.bit_length = 7'd8; send_beat(b);
		b.scale_factor = 32'sh10000; b.endian_sel = 2'd2; send_beat(b);
		b.endian_sel = ORDER_INTEL; send_beat(b);
		b.anchor_bit = 6'd56; b.phys_in = 64'hffffffffffff0000; send_beat(b);
		b.endian_sel = ORDER_MOTOROLA; b.anchor_bit = 6'd7; b.bit_length = 7'd64;
		b.phys_in = 64'h8000000000000000; b.scale_factor = 32'shffffffff; send_beat(b);
		b.endian_sel = ORDER_INTEL; b.anchor_bit = 6'd0; b.bit_length = 7'd16;
		b.min_limit = 64'sh50000; b.max_limit = 64'sh10000; b.phys_in = '0;
		b.scale_factor = 32'sh8000; send_beat(b);
		b.action = ACT_EXTRACT; b.raw_is_signed = 1'b1;
		b.scale_offset = 64'h7fffffffffffffff;
		send_beat(b);

		// Hold off until every outstanding result has drained.
		wait_drained();

		// Random: first a stretch without gaps, then gaps throughout.
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			idle_gaps = (n >= 200);
			send_beat(random_beat());
			if (n == 600) wait_drained();
		end

		wait_drained();
		repeat (80) @(posedge clk);
		$display("covered %0d beats: %0d load, %0d clear, %0d insert, %0d extract",
			board.checked, board.hits[0], board.hits[1], board.hits[2], board.hits[3]);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d pending", board.mismatches, board.pending.size());
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
